// ===== rtl/hbs_pkg.sv =====
// Shared types and constants for the height-map bilinear sampler.
// Depends on nothing; every other file of the block imports it.
package hbs_pkg;

  // Fixed field widths
  localparam int HEIGHT_W   = 16;
  localparam int POS_W      = 24;
  localparam int ROWCOL_W   = 6;
  localparam int DIM_REG_W  = 7;
  localparam int SHIFT_W    = 4;
  localparam int FRAC_W     = 8;
  localparam int GPOS_W     = POS_W - 1;        // non-negative position bits
  localparam int GIDX_W     = GPOS_W - FRAC_W;  // integer part of a grid coordinate
  localparam int CMP_W      = 16;               // width for index and size compares
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SHIFT  = 2'd2;

  localparam logic [DIM_REG_W-1:0] GRID_WIDTH_RST  = 7'd22;
  localparam logic [DIM_REG_W-1:0] GRID_LENGTH_RST = 7'd35;
  localparam logic [SHIFT_W-1:0]   CELL_SHIFT_RST  = 4'd0;

  // Coordinate stage to fetch stage
  typedef struct packed {
    logic                res;       // query that will give a result
    logic                in_range;
    logic                wr_en;     // grid write to perform
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fz;
    logic [HEIGHT_W-1:0] wdata;
  } grid_ctl_t;

  // Fetch stage to blend pipeline
  typedef struct packed {
    logic              res;
    logic              in_range;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fz;
  } fetch_ctl_t;

endpackage

// ===== rtl/hbs_if.sv =====
// Valid/ready channel interfaces for sampler requests and responses.
// Depends on hbs_pkg for field widths.
interface hbs_req_if;
  import hbs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [ROWCOL_W-1:0]        row;
  logic [ROWCOL_W-1:0]        col;
  logic signed [HEIGHT_W-1:0] height_value;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_z;

  modport source (output valid, opcode, row, col, height_value, pos_x, pos_z,
                  input ready);
  modport sink   (input valid, opcode, row, col, height_value, pos_x, pos_z,
                  output ready);
endinterface

interface hbs_rsp_if;
  import hbs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height;
  logic                       in_range;

  modport source (output valid, height, in_range, input ready);
  modport sink   (input valid, height, in_range, output ready);
endinterface

// ===== rtl/hbs_coord.sv =====
// Coordinate stages: position shift, range check, corner clamp and addresses.
// Depends on hbs_pkg; feeds hbs_fetch.
module hbs_coord #(
  parameter int MAX_DIM = 64,
  parameter int ADDR_W  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                take,
  input  logic                                opcode,
  input  logic [hbs_pkg::ROWCOL_W-1:0]        row,
  input  logic [hbs_pkg::ROWCOL_W-1:0]        col,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] height_value,
  input  logic signed [hbs_pkg::POS_W-1:0]    pos_x,
  input  logic signed [hbs_pkg::POS_W-1:0]    pos_z,
  input  logic [hbs_pkg::DIM_REG_W-1:0]       grid_width,
  input  logic [hbs_pkg::DIM_REG_W-1:0]       grid_length,
  input  logic [hbs_pkg::SHIFT_W-1:0]         cell_shift,
  output hbs_pkg::grid_ctl_t                  ctl,
  output logic [ADDR_W-1:0]                   a00,
  output logic [ADDR_W-1:0]                   a01,
  output logic [ADDR_W-1:0]                   a10,
  output logic [ADDR_W-1:0]                   a11
);
  import hbs_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] r,
                                                 input logic [ADDR_W-1:0] c);
    return ADDR_W'(r * ADDR_W'(MAX_DIM) + c);
  endfunction

  // Stage 1
  logic                s1_valid;
  logic                s1_query;
  logic [ROWCOL_W-1:0] s1_row;
  logic [ROWCOL_W-1:0] s1_col;
  logic [HEIGHT_W-1:0] s1_wdata;
  logic                s1_neg;
  logic [GPOS_W-1:0]   s1_gx;
  logic [GPOS_W-1:0]   s1_gz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_query <= (opcode == OP_QUERY);
      s1_row   <= row;
      s1_col   <= col;
      s1_wdata <= height_value;
      s1_neg   <= pos_x[POS_W-1] | pos_z[POS_W-1];
      s1_gx    <= pos_x[GPOS_W-1:0] >> cell_shift;
      s1_gz    <= pos_z[GPOS_W-1:0] >> cell_shift;
    end
  end

  // Stage 2
  logic [GIDX_W-1:0] idx_x, idx_z;
  logic [CMP_W-1:0]  w_eff, l_eff;
  logic [CMP_W-1:0]  x1_full, z1_full;
  logic              in_range;
  logic [IDX_W-1:0]  x0, z0, x1, z1;
  logic              wr_ok;
  logic [ADDR_W-1:0] wr_addr;
  grid_ctl_t         ctl_next;
  logic [ADDR_W-1:0] a00_next, a01_next, a10_next, a11_next;

  always_comb begin
    idx_x = s1_gx[GPOS_W-1:FRAC_W];
    idx_z = s1_gz[GPOS_W-1:FRAC_W];
    w_eff = (CMP_W'(grid_width) < CMP_W'(MAX_DIM)) ? CMP_W'(grid_width) : CMP_W'(MAX_DIM);
    l_eff = (CMP_W'(grid_length) < CMP_W'(MAX_DIM)) ? CMP_W'(grid_length) : CMP_W'(MAX_DIM);
    in_range = !s1_neg && (CMP_W'(idx_x) < w_eff) && (CMP_W'(idx_z) < l_eff);
    // clamp the far corner to the last column or row in use
    x1_full = (CMP_W'(idx_x) + CMP_W'(1) < w_eff) ? CMP_W'(idx_x) + CMP_W'(1)
                                                  : w_eff - CMP_W'(1);
    z1_full = (CMP_W'(idx_z) + CMP_W'(1) < l_eff) ? CMP_W'(idx_z) + CMP_W'(1)
                                                  : l_eff - CMP_W'(1);
    x0 = in_range ? idx_x[IDX_W-1:0] : '0;
    z0 = in_range ? idx_z[IDX_W-1:0] : '0;
    x1 = in_range ? x1_full[IDX_W-1:0] : '0;
    z1 = in_range ? z1_full[IDX_W-1:0] : '0;

    wr_ok   = !s1_query && (CMP_W'(s1_row) < CMP_W'(MAX_DIM))
                        && (CMP_W'(s1_col) < CMP_W'(MAX_DIM));
    wr_addr = wr_ok ? cell_addr(ADDR_W'(s1_row), ADDR_W'(s1_col)) : '0;

    a00_next = s1_query ? cell_addr(ADDR_W'(z0), ADDR_W'(x0)) : wr_addr;
    a01_next = cell_addr(ADDR_W'(z0), ADDR_W'(x1));
    a10_next = cell_addr(ADDR_W'(z1), ADDR_W'(x0));
    a11_next = cell_addr(ADDR_W'(z1), ADDR_W'(x1));

    ctl_next.res      = s1_valid && s1_query;
    ctl_next.in_range = in_range;
    ctl_next.wr_en    = s1_valid && wr_ok;
    ctl_next.fx       = s1_gx[FRAC_W-1:0];
    ctl_next.fz       = s1_gz[FRAC_W-1:0];
    ctl_next.wdata    = s1_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.res   <= 1'b0;
      ctl.wr_en <= 1'b0;
    end else if (adv) begin
      ctl.res   <= ctl_next.res;
      ctl.wr_en <= ctl_next.wr_en;
    end
    if (adv) begin
      ctl.in_range <= ctl_next.in_range;
      ctl.fx       <= ctl_next.fx;
      ctl.fz       <= ctl_next.fz;
      ctl.wdata    <= ctl_next.wdata;
      a00          <= a00_next;
      a01          <= a01_next;
      a10          <= a10_next;
      a11          <= a11_next;
    end
  end

endmodule

// ===== rtl/hbs_fetch.sv =====
// Grid storage and corner fetch stage: two copies of the height grid,
// one per corner row, each written together and read at two addresses.
// Depends on hbs_pkg; fed by hbs_coord, feeds hbs_blend.
module hbs_fetch #(
  parameter int MAX_DIM = 64,
  parameter int ADDR_W  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  hbs_pkg::grid_ctl_t                  ctl_in,
  input  logic [ADDR_W-1:0]                   a00,
  input  logic [ADDR_W-1:0]                   a01,
  input  logic [ADDR_W-1:0]                   a10,
  input  logic [ADDR_W-1:0]                   a11,
  output hbs_pkg::fetch_ctl_t                 ctl_out,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] h00,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] h01,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] h10,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] h11
);
  import hbs_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [HEIGHT_W-1:0] mem_near [DEPTH];
  logic [HEIGHT_W-1:0] mem_far  [DEPTH];

  // near row copy
  always_ff @(posedge clk) begin
    if (adv && ctl_in.wr_en) begin
      mem_near[a00] <= ctl_in.wdata;
    end
    if (adv) begin
      h00 <= mem_near[a00];
      h01 <= mem_near[a01];
    end
  end

  // far row copy
  always_ff @(posedge clk) begin
    if (adv && ctl_in.wr_en) begin
      mem_far[a00] <= ctl_in.wdata;
    end
    if (adv) begin
      h10 <= mem_far[a10];
      h11 <= mem_far[a11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.res <= 1'b0;
    end else if (adv) begin
      ctl_out.res <= ctl_in.res;
    end
    if (adv) begin
      ctl_out.in_range <= ctl_in.in_range;
      ctl_out.fx       <= ctl_in.fx;
      ctl_out.fz       <= ctl_in.fz;
    end
  end

endmodule

// ===== rtl/hbs_blend.sv =====
// Bilinear blend pipeline: weight products, x blend, z products, z blend,
// saturation and the output register. Depends on hbs_pkg.
module hbs_blend (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  hbs_pkg::fetch_ctl_t                 ctl,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] h00,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] h01,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] h10,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] h11,
  output logic                                out_valid,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] height,
  output logic                                in_range
);
  import hbs_pkg::*;

  localparam int WGT_W  = FRAC_W + 1;             // 0..256
  localparam int PX_W   = HEIGHT_W + WGT_W + 1;   // x products
  localparam int ROW_W  = HEIGHT_W + 2;           // blended row heights
  localparam int PZ_W   = ROW_W + WGT_W + 1;      // z products
  localparam int SUM_W  = PZ_W - FRAC_W + 1;

  // Stage 4: x weight products
  logic [WGT_W-1:0]       wx0, wx1;
  logic                   s4_res, s4_in;
  logic [FRAC_W-1:0]      s4_fz;
  logic signed [PX_W-1:0] p_b0, p_b1, p_t0, p_t1;

  assign wx0 = WGT_W'(1 << FRAC_W) - WGT_W'(ctl.fx);
  assign wx1 = WGT_W'(ctl.fx);

  // Stage 5: row blends
  logic signed [ROW_W-1:0] bot_next, top_next, bot, top;
  logic                    s5_res, s5_in;
  logic [FRAC_W-1:0]       s5_fz;

  assign bot_next = ROW_W'((p_b0 >>> FRAC_W) + (p_b1 >>> FRAC_W));
  assign top_next = ROW_W'((p_t0 >>> FRAC_W) + (p_t1 >>> FRAC_W));

  // Stage 6: z weight products
  logic [WGT_W-1:0]       wz0, wz1;
  logic signed [PZ_W-1:0] q0, q1;
  logic                   s6_res, s6_in;

  assign wz0 = WGT_W'(1 << FRAC_W) - WGT_W'(s5_fz);
  assign wz1 = WGT_W'(s5_fz);

  // Stage 7: z blend and saturate
  logic signed [SUM_W-1:0]    sum;
  logic signed [HEIGHT_W-1:0] sat;

  always_comb begin
    sum = SUM_W'((q0 >>> FRAC_W) + (q1 >>> FRAC_W));
    if (sum > SUM_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sum < -SUM_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_res    <= 1'b0;
      s5_res    <= 1'b0;
      s6_res    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s4_res    <= ctl.res;
      s5_res    <= s4_res;
      s6_res    <= s5_res;
      out_valid <= s6_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_in    <= ctl.in_range;
      s4_fz    <= ctl.fz;
      p_b0     <= PX_W'(h00) * PX_W'($signed({1'b0, wx0}));
      p_b1     <= PX_W'(h01) * PX_W'($signed({1'b0, wx1}));
      p_t0     <= PX_W'(h10) * PX_W'($signed({1'b0, wx0}));
      p_t1     <= PX_W'(h11) * PX_W'($signed({1'b0, wx1}));

      s5_in    <= s4_in;
      s5_fz    <= s4_fz;
      bot      <= bot_next;
      top      <= top_next;

      s6_in    <= s5_in;
      q0       <= PZ_W'(bot) * PZ_W'($signed({1'b0, wz0}));
      q1       <= PZ_W'(top) * PZ_W'($signed({1'b0, wz1}));

      in_range <= s6_in;
      height   <= s6_in ? sat : '0;
    end
  end

endmodule

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Top level of the height-map bilinear sampler: configuration registers,
// pipeline flow control and the coordinate, fetch and blend stages.
// Depends on hbs_pkg, hbs_if, hbs_coord, hbs_fetch and hbs_blend.
//
// Usage:
//   req carries one item per beat. opcode OP_WRITE stores height_value at
//   (row, col) and gives no response; OP_QUERY samples the grid at
//   (pos_x, pos_z) and gives exactly one rsp beat with height and in_range.
//   Responses come back in request order.
//   The cfg port (cfg_en, cfg_index, cfg_data) sets grid_width, grid_length
//   and cell_shift; write it only while no request is in flight.
// Timing:
//   Seven register stages in order: stage 1, stage 2, the fetch stage and
//   stages 4 to 7. One item per cycle is taken while rsp keeps up; every
//   stage holds one item and all stages advance together.
// Reset and stalls:
//   Reset empties the pipeline and loads width 22, length 35, shift 0. The
//   grid contents are not cleared; read only entries that were written.
//   While rsp holds a beat that is not taken, the whole pipeline freezes
//   and req.ready stays low; nothing is lost or repeated.
module heightmap_bilinear_sampler #(
  parameter int MAX_DIM = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  hbs_req_if.sink                          req,
  hbs_rsp_if.source                        rsp,
  input  logic                             cfg_en,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hbs_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

  logic [DIM_REG_W-1:0] grid_width;
  logic [DIM_REG_W-1:0] grid_length;
  logic [SHIFT_W-1:0]   cell_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_length <= GRID_LENGTH_RST;
      cell_shift  <= CELL_SHIFT_RST;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_REG_W-1:0];
        REG_GRID_LENGTH: grid_length <= cfg_data[DIM_REG_W-1:0];
        REG_CELL_SHIFT:  cell_shift  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance every stage unless the output holds an untaken beat
  logic adv;
  logic out_valid;

  assign adv       = !out_valid || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = out_valid;

  grid_ctl_t         c2;
  logic [ADDR_W-1:0] a00, a01, a10, a11;
  fetch_ctl_t        c3;
  logic signed [HEIGHT_W-1:0] h00, h01, h10, h11;

  hbs_coord #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_coord (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .take         (req.valid),
    .opcode       (req.opcode),
    .row          (req.row),
    .col          (req.col),
    .height_value (req.height_value),
    .pos_x        (req.pos_x),
    .pos_z        (req.pos_z),
    .grid_width   (grid_width),
    .grid_length  (grid_length),
    .cell_shift   (cell_shift),
    .ctl          (c2),
    .a00          (a00),
    .a01          (a01),
    .a10          (a10),
    .a11          (a11)
  );

  hbs_fetch #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_fetch (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_in  (c2),
    .a00     (a00),
    .a01     (a01),
    .a10     (a10),
    .a11     (a11),
    .ctl_out (c3),
    .h00     (h00),
    .h01     (h01),
    .h10     (h10),
    .h11     (h11)
  );

  hbs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl       (c3),
    .h00       (h00),
    .h01       (h01),
    .h10       (h10),
    .h11       (h11),
    .out_valid (out_valid),
    .height    (rsp.height),
    .in_range  (rsp.in_range)
  );

  // A grid write never carries a response, and a query never writes
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    !(c2.res && c2.wr_en))
    else $error("grid write and query flags set on one item");

  // A position outside the grid reads as zero height
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.in_range |-> rsp.height == '0)
    else $error("outside position gave nonzero height");

  // An in-range sample needs a grid of nonzero size
  a_in_range_dims: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.in_range |-> grid_width != '0 && grid_length != '0)
    else $error("in-range sample with an empty grid");

endmodule
